>>> hdl/fla_pkg.sv
`timescale 1ns / 1ps

package fla_pkg;

  // Action codes carried on in_tuser.
  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FAILURE_LIMIT  = 2'd0;
  localparam logic [1:0] REG_BLOCK_SECONDS  = 2'd1;
  localparam logic [1:0] REG_WINDOW_SECONDS = 2'd2;

  // Register reset values.
  localparam logic [7:0]  FAILURE_LIMIT_RST  = 8'd5;
  localparam logic [16:0] BLOCK_SECONDS_RST  = 17'd300;
  localparam logic [16:0] WINDOW_SECONDS_RST = 17'd600;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Fixed part of a table record: failures, last attempt, block end.
  localparam int FAIL_BITS = 8;
  localparam int TIME_BITS = 32;
  localparam int FIXED_REC_BITS = FAIL_BITS + 2 * TIME_BITS;

  // Result fields as they leave the block.
  typedef struct packed {
    logic       evicted;
    logic [7:0] failure_count;
    logic       entry_found;
    logic       blocked;
  } result_t;

  // a strictly before b, modulo 2^32.
  function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

>>> hdl/failed_attempt_lockout_table.sv
`timescale 1ns / 1ps

// Failed-attempt lockout table.
// Items arrive on the in_ stream: in_tuser carries the action (record a
// failure, query, clear) and in_tdata carries the source key and the current
// time in seconds. Every item produces exactly one result transfer on the
// out_ stream with the blocked flag, whether the key was present, the
// failure count after the item and whether an old entry was evicted.
// Registers are written through the cfg_ port, which is always ready; write
// it only while the block is idle.
// Each item is handled by a sequential scan: the table RAM is read once per
// entry, one entry per cycle over its single read port, followed by an update
// step that writes the chosen entry back for a recorded failure. One item is
// worked on at a time: the next input is taken only once the block is idle.
// The result sits in an output register; the next input is taken while it
// waits, but the update step of that next item holds until the register is
// free, so a stalled receiver stalls the block without losing anything.
// Reset clears all entry valid bits at once and restores the register
// defaults (limit 5, block 300 s, window 600 s); no clearing pass is needed.
module failed_attempt_lockout_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int KEY_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] source_key, [63:32] now_seconds
  input  logic [1:0]  in_tuser,   // [1:0] action
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] blocked, [1] entry_found,
                                  // [9:2] failure_count, [10] evicted, rest 0
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  // Effective key width: the key field itself is 32 bits wide.
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int RW = KW + fla_pkg::FIXED_REC_BITS;
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r;

  // Configuration registers.
  logic [7:0]  limit_r;
  logic [16:0] block_r;
  logic [16:0] window_r;

  // Latched item.
  logic [1:0]    act_r;
  logic [KW-1:0] key_r;
  logic [31:0]   now_r;

  // Scan bookkeeping.
  logic [CW-1:0] cnt_r;
  logic          rd_vld_r;
  logic          rd_last_r;
  logic [IW-1:0] rd_idx_r;

  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [7:0]    hit_fail_r;
  logic [31:0]   hit_last_r;
  logic [31:0]   hit_bu_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic          old_r;
  logic [IW-1:0] old_idx_r;
  logic [31:0]   old_age_r;

  logic [TABLE_ENTRIES-1:0] valid_r;

  logic               out_valid_r;
  fla_pkg::result_t   res_r;

  // RAM ports.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // Fields of the record read back during the scan.
  logic [KW-1:0] rd_key;
  logic [7:0]    rd_fail;
  logic [31:0]   rd_last;
  logic [31:0]   rd_bu;
  logic          rd_valid;
  logic [31:0]   rd_age;

  assign rd_key   = ram_rdata[RW-1 -: KW];
  assign rd_fail  = ram_rdata[2*fla_pkg::TIME_BITS +: fla_pkg::FAIL_BITS];
  assign rd_last  = ram_rdata[fla_pkg::TIME_BITS +: fla_pkg::TIME_BITS];
  assign rd_bu    = ram_rdata[0 +: fla_pkg::TIME_BITS];
  assign rd_valid = valid_r[rd_idx_r];
  assign rd_age   = now_r - rd_last;

  logic issue;
  logic out_free;
  logic in_xfer;

  assign issue     = (state_r == S_SCAN) && (cnt_r < CW'(TABLE_ENTRIES));
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign ram_raddr = cnt_r[IW-1:0];

  // Update step for a recorded failure. A fresh entry starts at count zero
  // with its block end just behind now, so it reads as not blocked.
  logic [7:0]    base_fail;
  logic [31:0]   base_last;
  logic [31:0]   base_bu;
  logic [31:0]   now_m1;
  logic          bu_live;
  logic [31:0]   bu_keep;
  logic [7:0]    fail_win;
  logic [7:0]    fail_inc;
  logic          at_limit;
  logic [31:0]   bu_new;
  logic          rec_blocked;
  logic [IW-1:0] slot;
  logic          do_evict;

  always_comb begin
    now_m1    = now_r - 32'd1;
    base_fail = hit_r ? hit_fail_r : 8'd0;
    base_last = hit_r ? hit_last_r : now_r;
    base_bu   = hit_r ? hit_bu_r : now_m1;
    bu_live   = fla_pkg::time_before(now_r, base_bu);
    bu_keep   = bu_live ? base_bu : now_m1;
    fail_win  = ((now_r - base_last) > {15'd0, window_r}) ? 8'd0 : base_fail;
    fail_inc  = (fail_win < fla_pkg::COUNT_MAX) ? fail_win + 8'd1 : fail_win;
    at_limit  = (fail_inc >= limit_r);
    bu_new    = at_limit ? now_r + {15'd0, block_r} : bu_keep;
    // An expired block end was moved to now - 1, which is never after now.
    rec_blocked = at_limit || bu_live;
    do_evict  = !hit_r && !free_r;
    slot      = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);
  end

  logic             upd_go;
  fla_pkg::result_t res_nxt;

  assign upd_go    = (state_r == S_UPD) && out_free;
  assign ram_we    = upd_go && (act_r == fla_pkg::ACT_RECORD);
  assign ram_waddr = slot;
  assign ram_wdata = {key_r, fail_inc, now_r, bu_new};

  always_comb begin
    res_nxt = '0;
    case (act_r)
      fla_pkg::ACT_RECORD: begin
        res_nxt.blocked       = rec_blocked;
        res_nxt.entry_found   = hit_r;
        res_nxt.failure_count = fail_inc;
        res_nxt.evicted       = do_evict;
      end
      fla_pkg::ACT_QUERY: begin
        res_nxt.entry_found = hit_r;
        if (hit_r) begin
          res_nxt.blocked       = fla_pkg::time_before(now_r, hit_bu_r);
          res_nxt.failure_count = hit_fail_r;
        end
      end
      fla_pkg::ACT_CLEAR: begin
        res_nxt.entry_found = hit_r;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  fla_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      old_r       <= 1'b0;
      limit_r     <= fla_pkg::FAILURE_LIMIT_RST;
      block_r     <= fla_pkg::BLOCK_SECONDS_RST;
      window_r    <= fla_pkg::WINDOW_SECONDS_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          fla_pkg::REG_FAILURE_LIMIT:  limit_r  <= cfg_data[7:0];
          fla_pkg::REG_BLOCK_SECONDS:  block_r  <= cfg_data;
          fla_pkg::REG_WINDOW_SECONDS: window_r <= cfg_data;
          default: begin
          end
        endcase
      end

      // A result leaving in the same cycle as a new one is loaded is
      // handled by the update step below.
      if (out_valid_r && out_tready && !upd_go) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r  <= issue;
      rd_last_r <= issue && (cnt_r == CW'(TABLE_ENTRIES - 1));
      if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end

      // Scan results: first matching entry, lowest free slot, and the valid
      // entry with the largest age (lowest index on a tie).
      if (rd_vld_r) begin
        if (rd_valid && (rd_key == key_r) && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!rd_valid && !free_r) begin
          free_r <= 1'b1;
        end
        if (rd_valid && (!old_r || (rd_age > old_age_r))) begin
          old_r <= 1'b1;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_SCAN;
            cnt_r   <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            old_r   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rd_vld_r && rd_last_r) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (act_r == fla_pkg::ACT_RECORD) begin
              valid_r[slot] <= 1'b1;
            end else if ((act_r == fla_pkg::ACT_CLEAR) && hit_r) begin
              valid_r[hit_idx_r] <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r <= in_tuser;
      key_r <= in_tdata[KW-1:0];
      now_r <= in_tdata[63:32];
    end
    if (issue) begin
      rd_idx_r <= cnt_r[IW-1:0];
    end
    if (rd_vld_r) begin
      if (rd_valid && (rd_key == key_r) && !hit_r) begin
        hit_idx_r  <= rd_idx_r;
        hit_fail_r <= rd_fail;
        hit_last_r <= rd_last;
        hit_bu_r   <= rd_bu;
      end
      if (!rd_valid && !free_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (rd_valid && (!old_r || (rd_age > old_age_r))) begin
        old_idx_r <= rd_idx_r;
        old_age_r <= rd_age;
      end
    end
    if (upd_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r};

endmodule

>>> hdl/fla_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
